FILE: rtl/cle_pkg.sv
// Shared types and constants of the circular list engine.
package cle_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AFTER = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AFTER = 3'd5,
      CMD_READ_ALL  = 3'd6,
      CMD_NOP       = 3'd7
   } cle_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } cle_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_ALLOC,
      S_LINK,
      S_VICT,
      S_FREE,
      S_RHEAD,
      S_READ
   } cle_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } cle_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic [STAT_W-1:0]        status;
      logic                     last;
   } cle_rsp_type;

endpackage

FILE: rtl/circular_list_engine.sv
// Top level of the circular list engine: command sequencer, list registers and memories.
//
// The engine keeps a circular singly linked list of signed 32-bit values in CAPACITY slots,
// with a tail pointer and a chain of free slots. A command transfer is taken at a rising
// edge where start is high and busy is low; busy then stays high until the command is
// finished. Every result transfer sits on rsp_data for exactly one cycle, marked by
// rsp_strobe, and the receiver must take it then because the engine cannot be stalled.
// Results on an empty or full list and the no-operation command are answered in the cycle
// after the command transfer without raising busy. Otherwise all link reads go through the
// single read port of the link memory, which the sequencer steps one link per cycle, and
// that walk sets the time: it grows with p for insert after and delete after position p
// (p of zero counts as one) and with the number of elements for delete back. Read out
// delivers one element per cycle, with last set on the final element. The single result
// of a command is on the ports from the edge at which busy falls, and during read out each
// result follows in the cycle after its element is read. The link memory resets to its
// free chain at once through per-entry valid bits, so there is no clearing pass after reset.
module circular_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cle_pkg::cle_req_type req_data,
   output logic                 rsp_strobe,
   output cle_pkg::cle_rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > cle_pkg::POS_W) ? CW : cle_pkg::POS_W;

   // Sequencer state and the list registers.
   cle_pkg::cle_state_type state_ff, state_in;
   cle_pkg::cle_cmd_type   cmd_ff, cmd_in;
   logic signed [cle_pkg::DATA_W-1:0] value_ff, value_in;
   logic [IW-1:0] cur_ff, cur_in;          // node under the walk, then the predecessor p
   logic [IW-1:0] plink_ff, plink_in;      // link of p: successor, or the victim of a delete
   logic [IW-1:0] new_slot_ff, new_slot_in;
   logic [SW-1:0] steps_ff, steps_in;      // links still to walk, or elements still to read
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] free_ff, free_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   cle_pkg::cle_rsp_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] rd_link;
   logic signed [cle_pkg::DATA_W-1:0] rd_value;
   logic          link_wr_en;
   logic [IW-1:0] link_wr_addr;
   logic [IW-1:0] link_wr_data;
   logic          value_wr_en;

   logic          is_empty;
   logic          is_full;
   logic [SW-1:0] pos_steps;
   cle_pkg::cle_cmd_type req_cmd;

   cle_link_ram #(
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   cle_value_ram #(
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_wr_en),
      .wr_addr (new_slot_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign req_cmd  = cle_pkg::cle_cmd_type'(req_data.command);

   // The walk starts at the tail, so reaching the node (position-1) links past the head
   // takes position links. Position zero behaves like position one. Going around the ring
   // more than once gives the circular wrap for free.
   assign pos_steps = (req_data.position == '0) ? SW'(1) : SW'(req_data.position);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cle_pkg::S_IDLE;
         tail_ff       <= '0;
         count_ff      <= '0;
         free_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      cur_ff      <= cur_in;
      plink_ff    <= plink_in;
      new_slot_ff <= new_slot_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      plink_in      = plink_ff;
      new_slot_in   = new_slot_ff;
      steps_in      = steps_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      rd_addr       = cur_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = cur_ff;
      link_wr_data  = plink_ff;
      value_wr_en   = 1'b0;

      unique case (state_ff)
         cle_pkg::S_IDLE: begin
            rd_addr = tail_ff;
            if (start) begin
               cmd_in   = req_cmd;
               value_in = req_data.value;
               cur_in   = tail_ff;
               steps_in = '0;
               unique case (req_cmd) inside
                  cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK: begin
                     if (is_full) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = cle_pkg::ST_FULL;
                        rsp_data_in.last   = 1'b1;
                     end else begin
                        state_in = cle_pkg::S_WALK;
                     end
                  end
                  cle_pkg::CMD_INS_AFTER: begin
                     if (is_empty || is_full) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = is_empty ? cle_pkg::ST_EMPTY : cle_pkg::ST_FULL;
                        rsp_data_in.last   = 1'b1;
                     end else begin
                        steps_in = pos_steps;
                        state_in = cle_pkg::S_WALK;
                     end
                  end
                  cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK, cle_pkg::CMD_DEL_AFTER,
                  cle_pkg::CMD_READ_ALL: begin
                     if (is_empty) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = cle_pkg::ST_EMPTY;
                        rsp_data_in.last   = 1'b1;
                     end else if (req_cmd == cle_pkg::CMD_READ_ALL) begin
                        steps_in = SW'(count_ff);
                        state_in = cle_pkg::S_RHEAD;
                     end else begin
                        // Delete back stops on the node before the tail, which is
                        // count-1 links from the tail; with one element that is the tail.
                        if (req_cmd == cle_pkg::CMD_DEL_BACK) begin
                           steps_in = (count_ff == CW'(1)) ? '0 : SW'(count_ff) - SW'(1);
                        end else if (req_cmd == cle_pkg::CMD_DEL_AFTER) begin
                           steps_in = pos_steps;
                        end
                        state_in = cle_pkg::S_WALK;
                     end
                  end
                  cle_pkg::CMD_NOP: begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = cle_pkg::ST_DONE;
                     rsp_data_in.last   = 1'b1;
                  end
               endcase
            end
         end

         cle_pkg::S_WALK: begin
            // The link of cur_ff arrives from the memory in this cycle.
            if (steps_ff == '0) begin
               plink_in = rd_link;
               if (cmd_ff inside {cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK,
                                  cle_pkg::CMD_INS_AFTER}) begin
                  rd_addr     = free_ff;
                  new_slot_in = free_ff;
                  state_in    = cle_pkg::S_ALLOC;
               end else if (count_ff == CW'(1)) begin
                  count_in = '0;
                  tail_in  = '0;
                  state_in = cle_pkg::S_FREE;
               end else begin
                  rd_addr  = rd_link;
                  state_in = cle_pkg::S_VICT;
               end
            end else begin
               cur_in   = rd_link;
               rd_addr  = rd_link;
               steps_in = steps_ff - SW'(1);
            end
         end

         cle_pkg::S_ALLOC: begin
            // The link of the fresh slot is the new head of the free chain.
            free_in      = rd_link;
            link_wr_en   = 1'b1;
            link_wr_addr = new_slot_ff;
            link_wr_data = is_empty ? new_slot_ff : plink_ff;
            value_wr_en  = 1'b1;
            state_in     = cle_pkg::S_LINK;
         end

         cle_pkg::S_LINK: begin
            link_wr_en   = !is_empty;
            link_wr_addr = cur_ff;
            link_wr_data = new_slot_ff;
            if (is_empty || (cmd_ff == cle_pkg::CMD_INS_BACK) ||
                ((cmd_ff == cle_pkg::CMD_INS_AFTER) && (cur_ff == tail_ff))) begin
               tail_in = new_slot_ff;
            end
            count_in           = count_ff + CW'(1);
            rsp_strobe_in      = 1'b1;
            rsp_data_in.status = cle_pkg::ST_DONE;
            rsp_data_in.last   = 1'b1;
            state_in           = cle_pkg::S_IDLE;
         end

         cle_pkg::S_VICT: begin
            // Bridge the predecessor over the victim.
            link_wr_en   = 1'b1;
            link_wr_addr = cur_ff;
            link_wr_data = rd_link;
            if (plink_ff == tail_ff) begin
               tail_in = cur_ff;
            end
            count_in = count_ff - CW'(1);
            state_in = cle_pkg::S_FREE;
         end

         cle_pkg::S_FREE: begin
            // The victim goes to the front of the free chain.
            link_wr_en         = 1'b1;
            link_wr_addr       = plink_ff;
            link_wr_data       = free_ff;
            free_in            = plink_ff;
            rsp_strobe_in      = 1'b1;
            rsp_data_in.status = cle_pkg::ST_DONE;
            rsp_data_in.last   = 1'b1;
            state_in           = cle_pkg::S_IDLE;
         end

         cle_pkg::S_RHEAD: begin
            // The link of the tail is the head; read its link and value next.
            rd_addr  = rd_link;
            cur_in   = rd_link;
            state_in = cle_pkg::S_READ;
         end

         cle_pkg::S_READ: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.value_out = rd_value;
            rsp_data_in.status    = cle_pkg::ST_DONE;
            rsp_data_in.last      = (steps_ff == SW'(1));
            rd_addr               = rd_link;
            cur_in                = rd_link;
            steps_in              = steps_ff - SW'(1);
            if (steps_ff == SW'(1)) begin
               state_in = cle_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cle_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != cle_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTH
   // A result that is not the last of its command is followed at once by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_data_ff.last) |=> rsp_strobe_ff)
      else $error("read out stream broke before its last element");

   // Every command that raises busy ends by handing over its final result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe_ff && rsp_data_ff.last))
      else $error("command finished without a final result");

   // The no-operation command answers in the next cycle and never raises busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == cle_pkg::CMD_NOP)) |=>
      (rsp_strobe_ff && rsp_data_ff.last && !busy))
      else $error("no-operation command was not answered at once");

   // The element count never goes beyond the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (count_ff <= CW'(CAPACITY)))
      else $error("element count exceeds capacity");
`endif

endmodule

FILE: rtl/cle_link_ram.sv
// Link memory with registered read and per-entry valid bits that model the free-chain reset.
module cle_link_ram #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [$clog2(DEPTH)-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [$clog2(DEPTH)-1:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0]    mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [AW-1:0]    rd_data_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // An entry never written still holds its reset link: the next slot, wrapping to zero.
   assign rd_data = rd_valid_ff ? rd_data_ff :
                    ((rd_addr_ff == AW'(DEPTH-1)) ? '0 : rd_addr_ff + AW'(1));

endmodule

FILE: rtl/cle_value_ram.sv
// Element value memory with one write port and one registered read port.
module cle_value_ram #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic signed [cle_pkg::DATA_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic signed [cle_pkg::DATA_W-1:0] rd_data
);

   logic signed [cle_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic signed [cle_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_circular_list_engine.sv
// Self-checking testbench for the circular list engine with a built-in list mirror.
module tb_circular_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY   = 16;
   localparam int SLOT_W     = $clog2(CAPACITY);
   // Random commands that follow the directed opening sequence of 26 commands.
   localparam int ITEM_COUNT = 304;

   // Traffic shapes for the random part. Growing and shrinking phases walk the list
   // between empty and full so that every depth is exercised.
   typedef enum int {
      MODE_GROW,
      MODE_SHRINK,
      MODE_MIXED,
      MODE_READ_HEAVY
   } traffic_mode_type;

   // The mirror keeps its own copy of the slot memories, the tail pointer, the free
   // chain and the element count. Every accepted command transfer is applied to it,
   // and the result transfers that the command must produce are queued in order.
   class circular_list_mirror;
      logic signed [cle_pkg::DATA_W-1:0] slot_value [CAPACITY];
      logic [SLOT_W-1:0]                 slot_link  [CAPACITY];
      logic [SLOT_W-1:0]                 tail_slot;
      logic [SLOT_W-1:0]                 free_head;
      int unsigned                       element_count;
      cle_pkg::cle_rsp_type              due_results [$];
      int                                errors;
      int                                results_checked;
      int                                full_replies;
      int                                empty_replies;
      int                                longest_read;
      int                                op_seen [8];

      function new();
         for (int i = 0; i < CAPACITY; i++) begin
            slot_value[i] = '0;
            slot_link[i]  = SLOT_W'((i + 1) % CAPACITY);
         end
         tail_slot     = '0;
         free_head     = '0;
         element_count = 0;
         errors        = 0;
         results_checked = 0;
         full_replies  = 0;
         empty_replies = 0;
         longest_read  = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      function void owe(logic signed [cle_pkg::DATA_W-1:0] v, cle_pkg::cle_status_type st,
                        logic is_last);
         cle_pkg::cle_rsp_type r;
         r.value_out = v;
         r.status    = st;
         r.last      = is_last;
         if (st == cle_pkg::ST_FULL) full_replies++;
         if (st == cle_pkg::ST_EMPTY) empty_replies++;
         due_results.push_back(r);
      endfunction

      // Walks position-1 links from the head, wrapping around the list.
      function logic [SLOT_W-1:0] walk_from_head(logic [cle_pkg::POS_W-1:0] position);
         int unsigned       steps;
         logic [SLOT_W-1:0] s;
         steps = (position > 0) ? (int'(position) - 1) % element_count : 0;
         s = slot_link[tail_slot];
         repeat (steps) s = slot_link[s];
         return s;
      endfunction

      // Takes the first free slot and links it in after slot p.
      function logic [SLOT_W-1:0] link_after(logic [SLOT_W-1:0] p,
                                             logic signed [cle_pkg::DATA_W-1:0] v);
         logic [SLOT_W-1:0] s;
         s = free_head;
         free_head = slot_link[s];
         slot_value[s] = v;
         if (element_count == 0) begin
            slot_link[s] = s;
            tail_slot = s;
         end else begin
            slot_link[s] = slot_link[p];
            slot_link[p] = s;
         end
         element_count++;
         return s;
      endfunction

      function void apply_command(cle_pkg::cle_req_type req);
         cle_pkg::cle_cmd_type op;
         logic [SLOT_W-1:0]    p;
         logic [SLOT_W-1:0]    s;
         logic [SLOT_W-1:0]    victim;
         op = cle_pkg::cle_cmd_type'(req.command);
         op_seen[req.command]++;
         case (op)
            cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK: begin
               if (element_count >= CAPACITY) begin
                  owe('0, cle_pkg::ST_FULL, 1'b1);
               end else begin
                  s = link_after(tail_slot, req.value);
                  if (op == cle_pkg::CMD_INS_BACK) tail_slot = s;
                  owe('0, cle_pkg::ST_DONE, 1'b1);
               end
            end
            cle_pkg::CMD_INS_AFTER: begin
               if (element_count == 0) begin
                  owe('0, cle_pkg::ST_EMPTY, 1'b1);
               end else if (element_count >= CAPACITY) begin
                  owe('0, cle_pkg::ST_FULL, 1'b1);
               end else begin
                  p = walk_from_head(req.position);
                  s = link_after(p, req.value);
                  if (p == tail_slot) tail_slot = s;
                  owe('0, cle_pkg::ST_DONE, 1'b1);
               end
            end
            cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK, cle_pkg::CMD_DEL_AFTER: begin
               if (element_count == 0) begin
                  owe('0, cle_pkg::ST_EMPTY, 1'b1);
               end else begin
                  if (op == cle_pkg::CMD_DEL_FRONT) begin
                     p = tail_slot;
                  end else if (op == cle_pkg::CMD_DEL_BACK) begin
                     p = slot_link[tail_slot];
                     for (int unsigned n = 1; n + 1 < element_count; n++) p = slot_link[p];
                     if (element_count == 1) p = tail_slot;
                  end else begin
                     p = walk_from_head(req.position);
                  end
                  victim = slot_link[p];
                  if (element_count <= 1) begin
                     element_count = 0;
                     tail_slot = '0;
                  end else begin
                     slot_link[p] = slot_link[victim];
                     if (victim == tail_slot) tail_slot = p;
                     element_count--;
                  end
                  slot_link[victim] = free_head;
                  free_head = victim;
                  owe('0, cle_pkg::ST_DONE, 1'b1);
               end
            end
            cle_pkg::CMD_READ_ALL: begin
               if (element_count == 0) begin
                  owe('0, cle_pkg::ST_EMPTY, 1'b1);
               end else begin
                  s = slot_link[tail_slot];
                  for (int unsigned n = 0; n < element_count; n++) begin
                     owe(slot_value[s], cle_pkg::ST_DONE, n + 1 == element_count);
                     s = slot_link[s];
                  end
                  if (element_count > longest_read) longest_read = element_count;
               end
            end
            default: owe('0, cle_pkg::ST_DONE, 1'b1);
         endcase
      endfunction

      function void compare_result(cle_pkg::cle_rsp_type got);
         cle_pkg::cle_rsp_type want;
         results_checked++;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding: expected none, actual %p",
                     $time, got);
            return;
         end
         want = due_results.pop_front();
         if (got.value_out !== want.value_out) begin
            errors++;
            $display("%0t: value_out mismatch: expected %0d, actual %0d",
                     $time, want.value_out, got.value_out);
         end
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
         end
      endfunction
   endclass

   logic                 clock    = 1'b0;
   logic                 reset    = 1'b1;
   logic                 start    = 1'b0;
   cle_pkg::cle_req_type req_data = '0;
   logic                 busy;
   logic                 rsp_strobe;
   cle_pkg::cle_rsp_type rsp_data;

   circular_list_mirror mirror = new();

   // Length of the list as the stimulus side sees it, used only to steer positions
   // and traffic modes. The mirror keeps the authoritative copy.
   int list_len   = 0;
   int burst_left = 0;

   circular_list_engine #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both channels are observed at the rising edge, where the values seen are the ones
   // settled before the edge. A command transfer happens when start is high and busy is
   // low; a result transfer happens whenever the strobe is high, because the engine
   // cannot be held off.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) mirror.apply_command(req_data);
         if (rsp_strobe) mirror.compare_result(rsp_data);
      end
   end

   // Idle time before a command: mostly none or a few cycles, now and then a long gap,
   // and occasional bursts where commands follow each other back to back.
   function int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = $urandom_range(10, 30);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function logic signed [cle_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // Positions mostly land inside the list or just past its end; the rest cover the
   // whole field, zero and wrap-around included.
   function logic [cle_pkg::POS_W-1:0] pick_position();
      if ($urandom_range(0, 99) < 60)
         return cle_pkg::POS_W'($urandom_range(1, list_len + 1));
      return cle_pkg::POS_W'($urandom_range(0, 31));
   endfunction

   function cle_pkg::cle_cmd_type pick_command(traffic_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (r < 75)
               return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_INS_FRONT,
                                                            cle_pkg::CMD_INS_AFTER));
            if (r < 85) return cle_pkg::CMD_READ_ALL;
            return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_DEL_FRONT,
                                                         cle_pkg::CMD_NOP));
         end
         MODE_SHRINK: begin
            if (r < 75)
               return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_DEL_FRONT,
                                                            cle_pkg::CMD_DEL_AFTER));
            if (r < 85) return cle_pkg::CMD_READ_ALL;
            if (r < 90) return cle_pkg::CMD_NOP;
            return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_INS_FRONT,
                                                         cle_pkg::CMD_INS_AFTER));
         end
         MODE_MIXED:
            return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_INS_FRONT,
                                                         cle_pkg::CMD_NOP));
         default: begin
            if (r < 40) return cle_pkg::CMD_READ_ALL;
            return cle_pkg::cle_cmd_type'($urandom_range(cle_pkg::CMD_INS_FRONT,
                                                         cle_pkg::CMD_NOP));
         end
      endcase
   endfunction

   // Presents one command and holds it until the engine takes the transfer. Start is
   // only lowered when a gap follows, so it gets one assignment per edge at most.
   task send_command(cle_pkg::cle_cmd_type op, logic signed [cle_pkg::DATA_W-1:0] v,
                     logic [cle_pkg::POS_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{command: op, value: v, position: pos};
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op)
         cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK: if (list_len < CAPACITY) list_len++;
         cle_pkg::CMD_INS_AFTER: if (list_len > 0 && list_len < CAPACITY) list_len++;
         cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK, cle_pkg::CMD_DEL_AFTER:
            if (list_len > 0) list_len--;
         default: ;
      endcase
   endtask

   initial begin
      traffic_mode_type mode;
      int               mode_left;
      int               drain_wait;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every command on the empty list is rejected with status empty, except the
      // front and back inserts; the no-operation command just answers done.
      send_command(cle_pkg::CMD_READ_ALL, '0, 5'd1);
      send_command(cle_pkg::CMD_DEL_FRONT, '0, 5'd1);
      send_command(cle_pkg::CMD_DEL_BACK, '0, 5'd1);
      send_command(cle_pkg::CMD_DEL_AFTER, '0, 5'd1);
      send_command(cle_pkg::CMD_INS_AFTER, 32'sd5, 5'd3);
      send_command(cle_pkg::CMD_NOP, 32'sh7FFF_FFFF, 5'd31);

      // Build up with the extreme values, position zero and a position that wraps.
      send_command(cle_pkg::CMD_INS_FRONT, 32'sh7FFF_FFFF, 5'd0);
      send_command(cle_pkg::CMD_INS_BACK, 32'sh8000_0000, 5'd31);
      send_command(cle_pkg::CMD_INS_AFTER, '0, 5'd0);
      send_command(cle_pkg::CMD_INS_AFTER, -1, 5'd31);

      // Fill to capacity, inserting after the tail along the way, then try every
      // kind of insert on the full list and read the whole list back.
      for (int i = 4; i < CAPACITY; i++) begin
         send_command(cle_pkg::cle_cmd_type'(i % 3), pick_value(), cle_pkg::POS_W'(i));
      end
      send_command(cle_pkg::CMD_INS_FRONT, 32'sd1, 5'd1);
      send_command(cle_pkg::CMD_INS_BACK, 32'sd2, 5'd1);
      send_command(cle_pkg::CMD_INS_AFTER, 32'sd3, 5'd16);
      send_command(cle_pkg::CMD_READ_ALL, '0, 5'd1);

      // Random traffic, starting by draining the full list.
      mode = MODE_SHRINK;
      mode_left = $urandom_range(8, 30);
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (mode_left == 0) begin
            mode = traffic_mode_type'($urandom_range(MODE_GROW, MODE_READ_HEAVY));
            mode_left = $urandom_range(8, 30);
         end
         mode_left--;
         if (mode == MODE_SHRINK && list_len == 0 && $urandom_range(0, 1)) mode = MODE_GROW;
         if (mode == MODE_GROW && list_len == CAPACITY && $urandom_range(0, 1))
            mode = MODE_SHRINK;
         send_command(pick_command(mode), pick_value(), pick_position());
      end
      start <= 1'b0;

      // Let the last command finish, then watch a little longer for stray results.
      drain_wait = 0;
      while (mirror.due_results.size() != 0 && drain_wait < 1000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (CAPACITY + 8) @(posedge clock);
      if (mirror.due_results.size() != 0) begin
         mirror.errors += mirror.due_results.size();
         $display("%0t: %0d expected results never arrived",
                  $time, mirror.due_results.size());
      end

      $display("Covered %0d inserts, %0d deletes, %0d read-outs and %0d no-ops.",
               mirror.op_seen[cle_pkg::CMD_INS_FRONT] + mirror.op_seen[cle_pkg::CMD_INS_BACK]
               + mirror.op_seen[cle_pkg::CMD_INS_AFTER],
               mirror.op_seen[cle_pkg::CMD_DEL_FRONT] + mirror.op_seen[cle_pkg::CMD_DEL_BACK]
               + mirror.op_seen[cle_pkg::CMD_DEL_AFTER],
               mirror.op_seen[cle_pkg::CMD_READ_ALL], mirror.op_seen[cle_pkg::CMD_NOP]);
      $display("Checked %0d results: %0d full and %0d empty rejections, longest read-out %0d.",
               mirror.results_checked, mirror.full_replies, mirror.empty_replies,
               mirror.longest_read);
      if (mirror.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: a correct run takes a small fraction of this.
   initial begin
      #1ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: circular_list_engine.f
rtl/cle_pkg.sv
rtl/cle_link_ram.sv
rtl/cle_value_ram.sv
rtl/circular_list_engine.sv
test/tb_circular_list_engine.sv
